[src/dms_pkg.sv]
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types, constants and the twiddle tables of the magnitude spectrum.
// ----------------------------------------------------------------------------
package dms_pkg;

  localparam int POINTS       = 128;
  localparam int TWIDDLE_BITS = 16;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 15;
  localparam int SHIFT_W  = 4;
  localparam int IDX_W    = $clog2(POINTS);
  localparam int TW_W     = TWIDDLE_BITS + 2;
  localparam int PROD_W   = SAMPLE_W + TW_W;
  localparam int ACC_W    = PROD_W + IDX_W;
  localparam int A_W      = ACC_W - TWIDDLE_BITS + 2;
  localparam int SQ_W     = 2 * A_W;
  localparam int R_W      = A_W + 1;
  localparam int V_W      = 2 * R_W;
  localparam int STEP_W   = $clog2(R_W);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT   = 2'd1;

  localparam logic signed [SAMPLE_W-1:0] TRIGGER_RESET = 16'sd32000;
  localparam logic [SHIFT_W-1:0]         SHIFT_RESET   = 4'd4;
  localparam logic [MAG_W-1:0]           MAG_MAX       = 15'h7fff;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1 << 30;

  typedef logic signed [TW_W-1:0] tw_arr_t [POINTS];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_STORE
  } state_e;

  typedef struct packed {
    logic             accept;
    logic [IDX_W-1:0] pos;
    logic             last;
    logic             acc_clr;
    logic             mac_issue;
    logic [IDX_W-1:0] frame_raddr;
    logic [IDX_W-1:0] tw_idx;
    logic             square;
    logic             root_init;
    logic             root_step;
    logic             store;
    logic [IDX_W-1:0] bin;
    logic             set_valid;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_blocked;
  } sts_t;

  // series term divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic longint unsigned taylor_div(longint unsigned t, int k, bit odd);
    longint unsigned res;
    res = t;
    if (odd) begin
      case (k)
        1:       res = t / 6;
        2:       res = t / 20;
        3:       res = t / 42;
        4:       res = t / 72;
        5:       res = t / 110;
        6:       res = t / 156;
        7:       res = t / 210;
        8:       res = t / 272;
        9:       res = t / 342;
        10:      res = t / 420;
        11:      res = t / 506;
        default: res = t / 600;
      endcase
    end else begin
      case (k)
        1:       res = t / 2;
        2:       res = t / 12;
        3:       res = t / 30;
        4:       res = t / 56;
        5:       res = t / 90;
        6:       res = t / 132;
        7:       res = t / 182;
        8:       res = t / 240;
        9:       res = t / 306;
        10:      res = t / 380;
        11:      res = t / 462;
        default: res = t / 552;
      endcase
    end
    return res;
  endfunction

  function automatic longint taylor_q30(longint unsigned a, bit odd);
    longint unsigned term;
    longint          sum;
    term = odd ? a : longint'(ONE_Q30);
    sum  = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = taylor_div(term, k, odd);
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic longint q30_to_tw(longint v);
    longint half;
    half = longint'(1) << (29 - TWIDDLE_BITS);
    return (v + half) >>> (30 - TWIDDLE_BITS);
  endfunction

  function automatic tw_arr_t build_tw(bit imag);
    tw_arr_t         tab;
    longint unsigned q;
    longint unsigned r;
    longint unsigned a;
    longint          c;
    longint          s;
    longint          cs;
    longint          sn;
    for (int m = 0; m < POINTS; m++) begin
      q  = longint'(4 * m) / POINTS;
      r  = longint'(4 * m) - q * POINTS;
      a  = (HALF_PI_Q30 * r) / POINTS;
      c  = q30_to_tw(taylor_q30(a, 1'b0));
      s  = q30_to_tw(taylor_q30(a, 1'b1));
      case (q % 4)
        0:       begin cs = c;  sn = s;  end
        1:       begin cs = -s; sn = c;  end
        2:       begin cs = -c; sn = -s; end
        default: begin cs = s;  sn = -c; end
      endcase
      tab[m] = imag ? TW_W'(-sn) : TW_W'(cs);
    end
    return tab;
  endfunction

  localparam tw_arr_t TW_RE = build_tw(1'b0);
  localparam tw_arr_t TW_IM = build_tw(1'b1);

endpackage

[src/dft_magnitude_spectrum.sv]
// ----------------------------------------------------------------------------
// dft_magnitude_spectrum
// Framed real DFT with scaled, saturated bin magnitudes, played one per sample.
// ----------------------------------------------------------------------------
// One sample is taken per transfer and answered by one result: bin i of the
// previous frame's spectrum (zeros before the first frame completes, trigger
// level in place of bin 0 in the played value). Between frames, input stalls
// only while the output is blocked. After the last sample of a frame, input
// stalls while the transform runs on one complex MAC per cycle: per bin
// POINTS MACs, drain of the MAC pipeline, squares, root init, R_W steps of
// bit-pair square root, then store of the bin.
module dft_magnitude_spectrum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [dms_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dms_pkg::SAMPLE_W-1:0] played_value_o,
  output logic [dms_pkg::MAG_W-1:0]           bin_magnitude_o,
  output logic                                frame_end_o,
  input  logic                                cfg_we_i,
  input  logic [dms_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dms_pkg::CFG_W-1:0]           cfg_data_i
);

  dms_pkg::cmd_t cmd;
  dms_pkg::sts_t sts;

  dms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dms_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_i        (sample_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .played_value_o  (played_value_o),
    .bin_magnitude_o (bin_magnitude_o),
    .frame_end_o     (frame_end_o)
  );

endmodule

[src/dms_ctrl.sv]
// ----------------------------------------------------------------------------
// dms_ctrl
// Sequencer: sample intake, bin and point loops, magnitude and root steps.
// ----------------------------------------------------------------------------
module dms_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dms_pkg::sts_t sts_i,
  output dms_pkg::cmd_t cmd_o
);

  localparam logic [dms_pkg::IDX_W-1:0] LAST_IDX = dms_pkg::IDX_W'(dms_pkg::POINTS - 1);
  localparam logic [dms_pkg::STEP_W-1:0] LAST_STEP = dms_pkg::STEP_W'(dms_pkg::R_W - 1);

  dms_pkg::state_e state_q, state_d;
  logic [dms_pkg::IDX_W-1:0]  pos_q, pos_d;
  logic [dms_pkg::IDX_W-1:0]  n_q, n_d;
  logic [dms_pkg::IDX_W-1:0]  k_q, k_d;
  logic [dms_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [dms_pkg::STEP_W-1:0] step_q, step_d;
  logic [dms_pkg::IDX_W:0]    idx_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dms_pkg::ST_IDLE;
      pos_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      n_q     <= n_d;
      k_q     <= k_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  assign idx_sum = {1'b0, idx_q} + {1'b0, k_q};

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    n_d     = n_q;
    k_d     = k_q;
    idx_d   = idx_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.pos         = pos_q;
    cmd_o.last        = (pos_q == LAST_IDX);
    cmd_o.frame_raddr = n_q;
    cmd_o.tw_idx      = idx_q;
    cmd_o.bin         = k_q;
    in_stall_o        = 1'b1;
    unique case (state_q)
      dms_pkg::ST_IDLE: begin
        in_stall_o   = sts_i.out_blocked;
        cmd_o.accept = in_valid_i && !sts_i.out_blocked;
        if (cmd_o.accept) begin
          if (pos_q == LAST_IDX) begin
            pos_d         = '0;
            k_d           = '0;
            n_d           = '0;
            idx_d         = '0;
            cmd_o.acc_clr = 1'b1;
            state_d       = dms_pkg::ST_MAC;
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      dms_pkg::ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        n_d = n_q + 1'b1;
        if (idx_sum >= (dms_pkg::IDX_W+1)'(dms_pkg::POINTS))
          idx_d = dms_pkg::IDX_W'(idx_sum - (dms_pkg::IDX_W+1)'(dms_pkg::POINTS));
        else
          idx_d = idx_sum[dms_pkg::IDX_W-1:0];
        if (n_q == LAST_IDX) begin
          n_d     = '0;
          state_d = dms_pkg::ST_DRAIN;
        end
      end
      dms_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = dms_pkg::ST_SQUARE;
      end
      dms_pkg::ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = dms_pkg::ST_ROOT_INIT;
      end
      dms_pkg::ST_ROOT_INIT: begin
        cmd_o.root_init = 1'b1;
        step_d          = '0;
        state_d         = dms_pkg::ST_ROOT;
      end
      dms_pkg::ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == LAST_STEP) state_d = dms_pkg::ST_STORE;
      end
      dms_pkg::ST_STORE: begin
        cmd_o.store = 1'b1;
        if (k_q == LAST_IDX) begin
          cmd_o.set_valid = 1'b1;
          state_d         = dms_pkg::ST_IDLE;
        end else begin
          k_d           = k_q + 1'b1;
          n_d           = '0;
          idx_d         = '0;
          cmd_o.acc_clr = 1'b1;
          state_d       = dms_pkg::ST_MAC;
        end
      end
      default: state_d = dms_pkg::ST_IDLE;
    endcase
  end

endmodule

[src/dms_dp.sv]
// ----------------------------------------------------------------------------
// dms_dp
// Datapath: frame and spectrum stores, complex MAC, squares, bit-pair root,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module dms_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  dms_pkg::cmd_t                         cmd_i,
  output dms_pkg::sts_t                         sts_o,
  input  logic signed [dms_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic                                  cfg_we_i,
  input  logic [dms_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [dms_pkg::CFG_W-1:0]             cfg_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [dms_pkg::SAMPLE_W-1:0]   played_value_o,
  output logic [dms_pkg::MAG_W-1:0]             bin_magnitude_o,
  output logic                                  frame_end_o
);

  logic signed [dms_pkg::SAMPLE_W-1:0] frame_mem [dms_pkg::POINTS];
  logic [dms_pkg::MAG_W-1:0]           spec_mem  [dms_pkg::POINTS];

  logic signed [dms_pkg::SAMPLE_W-1:0] trig_q;
  logic [dms_pkg::SHIFT_W-1:0]         shift_q;
  logic                                spec_valid_q;

  logic                                out_valid_q;
  logic signed [dms_pkg::SAMPLE_W-1:0] played_q;
  logic [dms_pkg::MAG_W-1:0]           mag_q;
  logic                                end_q;

  logic                                v1_q, v2_q;
  logic signed [dms_pkg::SAMPLE_W-1:0] x_q;
  logic signed [dms_pkg::TW_W-1:0]     twr_q, twi_q;
  logic signed [dms_pkg::PROD_W-1:0]   pr_q, pi_q;
  logic signed [dms_pkg::ACC_W-1:0]    accr_q, acci_q;

  logic [dms_pkg::ACC_W-1:0]  absr, absi;
  logic [dms_pkg::A_W-1:0]    ar, ai;
  logic [dms_pkg::SQ_W-1:0]   sqr_q, sqi_q;
  logic [dms_pkg::V_W-1:0]    rad_q, res_q, bit_q, trial;
  logic [dms_pkg::SHIFT_W:0]  sh_amt;
  logic [dms_pkg::V_W-1:0]    scaled;
  logic [dms_pkg::MAG_W-1:0]  mag_sat;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q  <= dms_pkg::TRIGGER_RESET;
      shift_q <= dms_pkg::SHIFT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dms_pkg::REG_TRIGGER_LEVEL) trig_q <= cfg_data_i;
      if (cfg_idx_i == dms_pkg::REG_SCALE_SHIFT) shift_q <= cfg_data_i[dms_pkg::SHIFT_W-1:0];
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) frame_mem[cmd_i.pos] <= sample_i;
    if (cmd_i.mac_issue) x_q <= frame_mem[cmd_i.frame_raddr];
  end

  // mac pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_issue) begin
      twr_q <= dms_pkg::TW_RE[cmd_i.tw_idx];
      twi_q <= dms_pkg::TW_IM[cmd_i.tw_idx];
    end
    pr_q <= x_q * twr_q;
    pi_q <= x_q * twi_q;
    if (cmd_i.acc_clr) begin
      accr_q <= '0;
      acci_q <= '0;
    end else if (v2_q) begin
      accr_q <= accr_q + dms_pkg::ACC_W'(pr_q);
      acci_q <= acci_q + dms_pkg::ACC_W'(pi_q);
    end
  end

  // magnitude
  assign absr = accr_q[dms_pkg::ACC_W-1] ? dms_pkg::ACC_W'(-accr_q) : accr_q;
  assign absi = acci_q[dms_pkg::ACC_W-1] ? dms_pkg::ACC_W'(-acci_q) : acci_q;
  assign ar   = dms_pkg::A_W'(absr >> (dms_pkg::TWIDDLE_BITS - 2));
  assign ai   = dms_pkg::A_W'(absi >> (dms_pkg::TWIDDLE_BITS - 2));
  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sqr_q <= ar * ar;
      sqi_q <= ai * ai;
    end
    if (cmd_i.root_init) begin
      rad_q <= dms_pkg::V_W'(sqr_q) + dms_pkg::V_W'(sqi_q);
      res_q <= '0;
      bit_q <= dms_pkg::V_W'(1) << (dms_pkg::V_W - 2);
    end else if (cmd_i.root_step) begin
      if (rad_q >= trial) begin
        rad_q <= rad_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign sh_amt  = {1'b0, shift_q} + (dms_pkg::SHIFT_W+1)'(2);
  assign scaled  = res_q >> sh_amt;
  assign mag_sat = (scaled > dms_pkg::V_W'(dms_pkg::MAG_MAX)) ? dms_pkg::MAG_MAX
                                                             : scaled[dms_pkg::MAG_W-1:0];

  // spectrum store and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.set_valid) spec_valid_q <= 1'b1;
      if (cmd_i.accept) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) spec_mem[cmd_i.bin] <= mag_sat;
    if (cmd_i.accept) begin
      end_q <= cmd_i.last;
      if (spec_valid_q) begin
        mag_q    <= spec_mem[cmd_i.pos];
        played_q <= (cmd_i.pos == '0) ? trig_q : $signed({1'b0, spec_mem[cmd_i.pos]});
      end else begin
        mag_q    <= '0;
        played_q <= '0;
      end
    end
  end

  assign sts_o.pipe_busy   = v1_q || v2_q;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign played_value_o  = played_q;
  assign bin_magnitude_o = mag_q;
  assign frame_end_o     = end_q;

  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_clr |-> !(v1_q || v2_q))
    else $error("accumulator cleared with products in flight");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !(v1_q || v2_q || cmd_i.mac_issue))
    else $error("sample taken during transform");
  a_store_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.square |-> !(v1_q || v2_q))
    else $error("magnitude taken before accumulation done");

endmodule
